### hdl/fsub_pkg.sv
// ----------------------------------------------------------------------------
// fsub_pkg
// shared types and constants for the first substring match block
// ----------------------------------------------------------------------------
package fsub_pkg;

   localparam int MAX_NEEDLE_DEF  = 32;
   localparam int OFFSET_BITS_DEF = 32;

   localparam int LEN_W          = 6;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_INDEX_W    = 3;
   localparam int NEEDLE_WORDS   = 4;
   localparam int WORD_BYTES     = 8;
   localparam int NEEDLE_BYTES   = NEEDLE_WORDS * WORD_BYTES;
   localparam int NEEDLE_IDX_W   = $clog2(NEEDLE_BYTES);
   localparam int WORD_SEL_W     = $clog2(NEEDLE_WORDS);
   localparam int BYTE_SEL_W     = $clog2(WORD_BYTES);
   localparam int DATA_W         = 8;
   localparam int MATCH_OFFSET_W = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEEDLE_LENGTH = 3'd0,
      CSR_NEEDLE_WORD_0 = 3'd1,
      CSR_NEEDLE_WORD_1 = 3'd2,
      CSR_NEEDLE_WORD_2 = 3'd3,
      CSR_NEEDLE_WORD_3 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]                          needle_length;
      logic [NEEDLE_WORDS-1:0][CSR_DATA_W-1:0]   needle_words;
   } needle_cfg_type;

endpackage

### hdl/first_substring_match_top.sv
// ----------------------------------------------------------------------------
// first_substring_match_top
// first occurrence search of a configured needle in a byte stream
// an accepted transaction is registered in the compare stage, then in the output register
// throughput: one byte per cycle, set by the single window compare stage
// the input stalls only while a result waits in the output register
// reset clears configuration, stream state and both valid registers
// ----------------------------------------------------------------------------
module first_substring_match_top #(
   parameter int MAX_NEEDLE  = fsub_pkg::MAX_NEEDLE_DEF,
   parameter int OFFSET_BITS = fsub_pkg::OFFSET_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fsub_pkg::DATA_W-1:0]           req_data_byte,
   input  logic                                  req_last_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [fsub_pkg::MATCH_OFFSET_W-1:0]   rsp_match_offset,
   input  logic                                  csr_write_en,
   input  logic [fsub_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fsub_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam logic [OFFSET_BITS-1:0] SEEN_MAX = '1;
   localparam int OFF_WIDE_W = (OFFSET_BITS > fsub_pkg::MATCH_OFFSET_W) ?
                               OFFSET_BITS : fsub_pkg::MATCH_OFFSET_W;
   localparam logic [OFF_WIDE_W-1:0] REPORT_MAX =
      OFF_WIDE_W'({fsub_pkg::MATCH_OFFSET_W{1'b1}});

   fsub_pkg::needle_cfg_type     cfg;
   logic                         match_all;
   logic [fsub_pkg::LEN_W-1:0]   length_eff;
   logic [fsub_pkg::LEN_W-1:0]   length_m1;

   logic                         req_accept;
   logic                         s1_adv;
   logic                         has_result;
   logic                         hit;
   logic                         out_free;
   logic [OFFSET_BITS-1:0]       off_seen;
   logic [OFF_WIDE_W-1:0]        off_wide;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_last_ff;
   logic [OFFSET_BITS-1:0]       s1_seen_ff;
   logic [OFFSET_BITS-1:0]       bytes_seen_ff, bytes_seen_in;
   logic                         match_reported_ff, match_reported_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [fsub_pkg::MATCH_OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   fsub_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   fsub_window #(
      .MAX_NEEDLE (MAX_NEEDLE)
   ) u_window (
      .clock      (clock),
      .shift_en   (req_accept),
      .data_byte  (req_data_byte),
      .cfg        (cfg),
      .match_all  (match_all),
      .length_eff (length_eff)
   );

   assign length_m1 = length_eff - fsub_pkg::LEN_W'(1);

   // compare stage
   always_comb begin
      hit = s1_valid_ff && !match_reported_ff && (length_eff != '0) &&
            (s1_seen_ff >= OFFSET_BITS'(length_m1)) && match_all;
      if (s1_seen_ff == SEEN_MAX) begin
         off_seen = SEEN_MAX;
      end else begin
         off_seen = s1_seen_ff - OFFSET_BITS'(length_m1);
      end
      off_wide = OFF_WIDE_W'(off_seen);
      has_result = hit || (s1_valid_ff && s1_last_ff && !match_reported_ff);
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_adv     = s1_valid_ff && (!has_result || out_free);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      bytes_seen_in = bytes_seen_ff;
      if (req_accept) begin
         if (req_last_byte) begin
            bytes_seen_in = '0;
         end else if (bytes_seen_ff != SEEN_MAX) begin
            bytes_seen_in = bytes_seen_ff + OFFSET_BITS'(1);
         end
      end

      match_reported_in = match_reported_ff;
      if (s1_adv) begin
         match_reported_in = s1_last_ff ? 1'b0 : (match_reported_ff || hit);
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff && has_result;
         rsp_found_in = hit;
         if (!hit) begin
            rsp_offset_in = '0;
         end else if (off_wide > REPORT_MAX) begin
            rsp_offset_in = '1;
         end else begin
            rsp_offset_in = off_wide[fsub_pkg::MATCH_OFFSET_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         bytes_seen_ff     <= '0;
         match_reported_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         s1_valid_ff       <= s1_valid_in;
         bytes_seen_ff     <= bytes_seen_in;
         match_reported_ff <= match_reported_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_last_ff <= req_last_byte;
         s1_seen_ff <= bytes_seen_ff;
      end
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule

### hdl/fsub_csr.sv
// ----------------------------------------------------------------------------
// fsub_csr
// needle length and needle word registers behind the write port
// ----------------------------------------------------------------------------
module fsub_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [fsub_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsub_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output fsub_pkg::needle_cfg_type             cfg
);

   fsub_pkg::needle_cfg_type cfg_ff;
   fsub_pkg::needle_cfg_type cfg_in;
   logic [fsub_pkg::WORD_SEL_W-1:0] word_sel;

   assign word_sel = fsub_pkg::WORD_SEL_W'(csr_index - 
                     fsub_pkg::CSR_INDEX_W'(fsub_pkg::CSR_NEEDLE_WORD_0));

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (fsub_pkg::csr_index_type'(csr_index)) inside
            fsub_pkg::CSR_NEEDLE_LENGTH: begin
               cfg_in.needle_length = csr_wdata[fsub_pkg::LEN_W-1:0];
            end
            fsub_pkg::CSR_NEEDLE_WORD_0, fsub_pkg::CSR_NEEDLE_WORD_1,
            fsub_pkg::CSR_NEEDLE_WORD_2, fsub_pkg::CSR_NEEDLE_WORD_3: begin
               cfg_in.needle_words[word_sel] = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/fsub_window.sv
// ----------------------------------------------------------------------------
// fsub_window
// shift window of recent bytes and parallel compare against the needle
// ----------------------------------------------------------------------------
module fsub_window #(
   parameter int MAX_NEEDLE = fsub_pkg::MAX_NEEDLE_DEF
) (
   input  logic                              clock,
   input  logic                              shift_en,
   input  logic [fsub_pkg::DATA_W-1:0]       data_byte,
   input  fsub_pkg::needle_cfg_type          cfg,
   output logic                              match_all,
   output logic [fsub_pkg::LEN_W-1:0]        length_eff
);

   logic [fsub_pkg::DATA_W-1:0] window_ff [MAX_NEEDLE];
   logic [fsub_pkg::DATA_W-1:0] window_in [MAX_NEEDLE];
   logic [fsub_pkg::DATA_W-1:0] needle_bytes [fsub_pkg::NEEDLE_BYTES];
   logic [MAX_NEEDLE-1:0]       slot_ok;

   always_comb begin
      window_in[0] = data_byte;
      for (int k = 1; k < MAX_NEEDLE; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      for (int j = 0; j < fsub_pkg::NEEDLE_BYTES; j++) begin
         needle_bytes[j] = cfg.needle_words[j / fsub_pkg::WORD_BYTES]
                           [(j % fsub_pkg::WORD_BYTES) * fsub_pkg::DATA_W +: fsub_pkg::DATA_W];
      end
   end

   // clamp length to the window depth
   always_comb begin
      if (cfg.needle_length > fsub_pkg::LEN_W'(MAX_NEEDLE)) begin
         length_eff = fsub_pkg::LEN_W'(MAX_NEEDLE);
      end else begin
         length_eff = cfg.needle_length;
      end
   end

   // slot k holds the byte k steps ago, matched against needle byte len-1-k
   always_comb begin
      logic [fsub_pkg::LEN_W-1:0] pos;
      for (int k = 0; k < MAX_NEEDLE; k++) begin
         pos = length_eff - fsub_pkg::LEN_W'(1) - fsub_pkg::LEN_W'(k);
         if (fsub_pkg::LEN_W'(k) < length_eff) begin
            slot_ok[k] = (needle_bytes[pos[fsub_pkg::NEEDLE_IDX_W-1:0]] == window_ff[k]);
         end else begin
            slot_ok[k] = 1'b1;
         end
      end
   end

   assign match_all = &slot_ok;

endmodule

### hdl/fsub_chk.sv
// ----------------------------------------------------------------------------
// fsub_chk
// port level checks for the first substring match block
// ----------------------------------------------------------------------------
module fsub_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_found,
   input logic [fsub_pkg::MATCH_OFFSET_W-1:0]   rsp_match_offset
);

   // no result right after reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
                                 $stable(rsp_match_offset))
      else $error("stalled result changed");

   // not found carries a zero offset
   a_zero_offset : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("not found with nonzero offset");

   // input only stalls while a result is waiting
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // a new result follows a transaction through the compare and output registers
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without input transaction");

endmodule

bind first_substring_match_top fsub_chk u_fsub_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_match_offset (rsp_match_offset)
);
